// File: sv/u8d_pkg.sv
// Shared types, status codes and helpers for the UTF-8 stream decoder.
package u8d_pkg;

  localparam int CpW     = 21;
  localparam int StatusW = 2;

  localparam logic [StatusW-1:0] StOk        = 2'd0;
  localparam logic [StatusW-1:0] StBadCont   = 2'd1;
  localparam logic [StatusW-1:0] StTruncated = 2'd2;

  localparam logic [7:0] ByteAsciiLimit = 8'h80;
  localparam logic [7:0] ByteLead4      = 8'hf0;
  localparam logic [7:0] ByteLead3      = 8'he0;
  localparam logic [7:0] MaskCont       = 8'h3f;
  localparam logic [7:0] MaskLead4      = 8'h07;
  localparam logic [7:0] MaskLead3      = 8'h0f;
  localparam logic [7:0] MaskLead2      = 8'h1f;

  typedef struct packed {
    logic [CpW-1:0] acc;
    logic [1:0]     pend;
    logic           bad;
  } u8d_state_t;

  typedef struct packed {
    logic               valid;
    logic [CpW-1:0]     code_point;
    logic [StatusW-1:0] status;
    logic               end_of_string;
  } u8d_result_t;

  // Shift the gathered payload left by six bits per missing byte.
  function automatic logic [CpW-1:0] zero_pad(input logic [CpW-1:0] acc,
                                              input logic [1:0] pend);
    logic [CpW-1:0] r;
    r = acc;
    case (pend)
      2'd1:    r = {acc[CpW-7:0], 6'b0};
      2'd2:    r = {acc[CpW-13:0], 12'b0};
      2'd3:    r = {acc[CpW-19:0], 18'b0};
      default: r = acc;
    endcase
    return r;
  endfunction

endpackage

// File: sv/u8d_step.sv
// Per-byte decode: next sequence state and the optional result.
module u8d_step
  import u8d_pkg::*;
(
  input  u8d_state_t  cur,
  input  logic [7:0]  data_byte,
  input  logic        last,
  output u8d_state_t  nxt,
  output u8d_result_t res
);

  u8d_state_t lead_st;
  u8d_state_t cont_st;

  always_comb begin
    lead_st.bad = 1'b0;
    if (data_byte >= ByteLead4) begin
      lead_st.acc  = CpW'(data_byte & MaskLead4);
      lead_st.pend = 2'd3;
    end else if (data_byte >= ByteLead3) begin
      lead_st.acc  = CpW'(data_byte & MaskLead3);
      lead_st.pend = 2'd2;
    end else begin
      lead_st.acc  = CpW'(data_byte & MaskLead2);
      lead_st.pend = 2'd1;
    end

    cont_st.acc  = {cur.acc[CpW-7:0], 6'(data_byte & MaskCont)};
    cont_st.bad  = cur.bad | (data_byte < ByteAsciiLimit);
    cont_st.pend = cur.pend - 2'd1;
  end

  always_comb begin
    nxt                 = '0;
    res.valid           = 1'b0;
    res.code_point      = '0;
    res.status          = StOk;
    res.end_of_string   = 1'b0;

    if (cur.pend == 2'd0) begin
      if (data_byte == 8'd0) begin
        res.valid         = 1'b1;
        res.end_of_string = 1'b1;
      end else if (data_byte < ByteAsciiLimit) begin
        res.valid         = 1'b1;
        res.code_point    = CpW'(data_byte);
        res.end_of_string = last;
      end else if (last) begin
        res.valid         = 1'b1;
        res.code_point    = zero_pad(lead_st.acc, lead_st.pend);
        res.status        = StTruncated;
        res.end_of_string = 1'b1;
      end else begin
        nxt = lead_st;
      end
    end else if (data_byte == 8'd0) begin
      // NUL inside a sequence closes the string
      res.valid         = 1'b1;
      res.code_point    = zero_pad(cur.acc, cur.pend);
      res.status        = StTruncated;
      res.end_of_string = 1'b1;
    end else if (cont_st.pend == 2'd0) begin
      res.valid         = 1'b1;
      res.code_point    = cont_st.acc;
      res.status        = cont_st.bad ? StBadCont : StOk;
      res.end_of_string = last;
    end else if (last) begin
      res.valid         = 1'b1;
      res.code_point    = zero_pad(cont_st.acc, cont_st.pend);
      res.status        = StTruncated;
      res.end_of_string = 1'b1;
    end else begin
      nxt = cont_st;
    end
  end

endmodule

// File: sv/utf8_stream_decoder.sv
// An input byte is registered, and its result is registered again before the master side sees it.
// Throughput: one byte per cycle; the byte register and the result register
// form a two-stage pipeline that advances whenever the result stage is free.
// Reset (rst, synchronous): clears sequence state and both valid flags.
// Bytes that open or continue a sequence produce no result transaction.
module utf8_stream_decoder
  import u8d_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] data_byte
  input  logic               s_axis_tlast,   // last
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [23:0]        m_axis_tdata,   // [20:0] code_point, [23:21] zero
  output logic [StatusW-1:0] m_axis_tuser,   // [1:0] status
  output logic               m_axis_tlast    // end_of_string
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;

  u8d_state_t  st;
  u8d_state_t  st_next;
  u8d_result_t res;

  logic               out_valid;
  logic [CpW-1:0]     out_cp;
  logic [StatusW-1:0] out_status;
  logic               out_eos;

  logic advance;
  logic fire;

  assign advance       = !out_valid || m_axis_tready;
  assign fire          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  u8d_step u_step (
    .cur       (st),
    .data_byte (in_byte),
    .last      (in_last),
    .nxt       (st_next),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (fire) begin
        st <= st_next;
      end
      if (advance) begin
        out_valid <= fire && res.valid;
      end
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
    if (fire && res.valid) begin
      out_cp     <= res.code_point;
      out_status <= res.status;
      out_eos    <= res.end_of_string;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_cp};
  assign m_axis_tuser  = out_status;
  assign m_axis_tlast  = out_eos;

  // Idle decoder holds no stale payload or error flag.
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    st.pend == 2'd0 |-> (st.acc == '0 && !st.bad))
    else $error("sequence state not cleared while idle");

  // A result that closes the string leaves the decoder idle.
  a_eos_clears: assert property (@(posedge clk) disable iff (rst)
    fire && res.valid && res.end_of_string |=> st == '0)
    else $error("state not cleared after end of string");

  // Truncation only ever happens at the end of a string.
  a_trunc_eos: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == StTruncated |-> m_axis_tlast)
    else $error("truncated result without end of string");

  // Status code 3 is never produced.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == StOk || m_axis_tuser == StBadCont
                       || m_axis_tuser == StTruncated))
    else $error("invalid status code");

endmodule
